[sv/rpfc_pkg.sv]
// ----------------------------------------------------------------------------
// rpfc_pkg
// Shared types, codes and helpers for the ramp pattern frame checker.
// ----------------------------------------------------------------------------
package rpfc_pkg;

	localparam int MaxRowsDef     = 1024;
	localparam int MaxChannelsDef = 32;

	localparam int SampleW   = 16;
	localparam int HistDepth = 65536;
	localparam int RowsRegW  = 11;
	localparam int ChRegW    = 6;
	localparam int CfgW      = 11;
	localparam int CfgIdxW   = 2;

	localparam logic [RowsRegW-1:0] RowsReset = 11'd1024;
	localparam logic [ChRegW-1:0]   ChReset   = 6'd32;
	localparam logic [14:0]         DevMax    = 15'h7FFF;

	localparam logic [CfgIdxW-1:0] REG_ROWS     = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CHANNELS = 2'd1;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_HCLR,
		OP_ST_INIT,
		OP_ST_CAP,
		OP_ST_INC,
		OP_WALK_INIT,
		OP_CL_CAP,
		OP_SC_INIT,
		OP_SC_CAP,
		OP_SC_SAVE,
		OP_EQ_INIT,
		OP_EQ_CAP,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   swap;
		logic   load_en;
	} dp_cmd_t;

	typedef struct packed {
		logic hclr_done;
		logic walk_first;
		logic row_end;
		logic ch_last;
		logic eq_stop;
		logic last_sample;
		logic out_busy;
		logic one_row;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_HCLR,
		S_LOAD,
		S_ST_INIT,
		S_ST_RD,
		S_ST_CAP,
		S_ST_INC,
		S_CL_INIT,
		S_CL_RD,
		S_CL_CAP,
		S_SC_INIT,
		S_SC_RD,
		S_SC_CAP,
		S_SC_SAVE,
		S_EQ_INIT,
		S_EQ_RD,
		S_EQ_CAP,
		S_OUT
	} ctrl_state_t;

	function automatic logic [SampleW-1:0] bswap(input logic [SampleW-1:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

[sv/rpfc_ram.sv]
// ----------------------------------------------------------------------------
// rpfc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpfc_ram #(
	parameter int W = 16,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/rpfc_ctrl.sv]
// ----------------------------------------------------------------------------
// rpfc_ctrl
// Sequencer: histogram clear, frame load, per-orientation passes, equality pass, output.
// ----------------------------------------------------------------------------
module rpfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rpfc_pkg::dp_stat_t st,
	output rpfc_pkg::dp_cmd_t  cmd
);
	import rpfc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        swap_q, swap_d;
	logic        accept;

	assign in_ready = (state_q == S_LOAD) && !(st.out_busy && st.last_sample);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HCLR;
			swap_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			swap_q  <= swap_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		swap_d      = swap_q;
		cmd.op      = OP_NONE;
		cmd.swap    = swap_q;
		cmd.load_en = in_ready;
		case (state_q)
			S_HCLR: begin
				cmd.op = OP_HCLR;
				if (st.hclr_done) state_d = S_LOAD;
			end
			S_LOAD: begin
				swap_d = 1'b0;
				if (accept && st.last_sample) state_d = S_ST_INIT;
			end
			S_ST_INIT: begin
				cmd.op  = OP_ST_INIT;
				state_d = S_ST_RD;
			end
			S_ST_RD: state_d = S_ST_CAP;
			S_ST_CAP: begin
				cmd.op = OP_ST_CAP;
				if (!st.walk_first) state_d = S_ST_INC;
				else if (st.row_end) state_d = S_CL_INIT;
				else state_d = S_ST_RD;
			end
			S_ST_INC: begin
				cmd.op  = OP_ST_INC;
				state_d = st.row_end ? S_CL_INIT : S_ST_RD;
			end
			S_CL_INIT: begin
				cmd.op  = OP_WALK_INIT;
				state_d = S_CL_RD;
			end
			S_CL_RD: state_d = S_CL_CAP;
			S_CL_CAP: begin
				cmd.op  = OP_CL_CAP;
				state_d = st.row_end ? S_SC_INIT : S_CL_RD;
			end
			S_SC_INIT: begin
				cmd.op  = OP_SC_INIT;
				state_d = S_SC_RD;
			end
			S_SC_RD: state_d = S_SC_CAP;
			S_SC_CAP: begin
				cmd.op  = OP_SC_CAP;
				state_d = (st.row_end && st.ch_last) ? S_SC_SAVE : S_SC_RD;
			end
			S_SC_SAVE: begin
				cmd.op = OP_SC_SAVE;
				if (!swap_q) begin
					swap_d  = 1'b1;
					state_d = S_ST_INIT;
				end else begin
					swap_d  = 1'b0;
					state_d = st.one_row ? S_OUT : S_EQ_INIT;
				end
			end
			S_EQ_INIT: begin
				cmd.op  = OP_EQ_INIT;
				state_d = S_EQ_RD;
			end
			S_EQ_RD: state_d = S_EQ_CAP;
			S_EQ_CAP: begin
				cmd.op  = OP_EQ_CAP;
				state_d = st.eq_stop ? S_OUT : S_EQ_RD;
			end
			S_OUT: begin
				cmd.op  = OP_OUT;
				state_d = S_LOAD;
			end
			default: state_d = S_HCLR;
		endcase
	end

	a_frame_end_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept && st.last_sample |=> state_q == S_ST_INIT)
		else $error("frame end did not start the check");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !in_ready)
		else $error("ready outside load");

	a_swap_only_in_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EQ_CAP || state_q == S_LOAD) |-> !swap_q)
		else $error("swapped orientation left on");
endmodule

[sv/rpfc_dp.sv]
// ----------------------------------------------------------------------------
// rpfc_dp
// Datapath: frame store, delta histogram, walk counters, scoring, equality check and output.
// ----------------------------------------------------------------------------
module rpfc_dp #(
	parameter int MAX_ROWS     = 1024,
	parameter int MAX_CHANNELS = 32,
	localparam int NRW = $clog2(MAX_ROWS + 1),
	localparam int NCW = $clog2(MAX_CHANNELS + 1),
	localparam int TW  = $clog2(MAX_ROWS * MAX_CHANNELS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rpfc_pkg::dp_cmd_t  cmd,
	output rpfc_pkg::dp_stat_t st,
	input  logic [NRW-1:0]    nrows,
	input  logic [NCW-1:0]    nch,
	input  logic [TW-1:0]     total,
	input  logic              restart,
	input  logic              in_valid,
	input  logic [15:0]       sample,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              orientation,
	output logic [1:0]        verdict,
	output logic [5:0]        clean_channels,
	output logic [14:0]       deviation_total,
	output logic [15:0]       ramp_stride,
	output logic [4:0]        bad_channel,
	output logic [9:0]        bad_row,
	output logic [15:0]       bad_got,
	output logic [15:0]       bad_want,
	output logic              rows_equal,
	output logic [9:0]        first_unequal_row,
	output logic              last_result
);
	import rpfc_pkg::*;

	localparam int AW  = $clog2(MAX_ROWS * MAX_CHANNELS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int HCW = $clog2(MAX_ROWS);
	localparam int HAW = $clog2(HistDepth);
	localparam int DSW = ((HCW > 15) ? HCW : 15) + 1;

	// load
	logic [AW-1:0] pos_q;
	logic          accept, fs_we;

	// walk
	logic [AW-1:0]      addr_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      ch_q;
	logic               first_q;
	logic [SampleW-1:0] prev_q, fs_rdata, rd_val;

	// histogram
	logic [HAW-1:0] clr_q, h_raddr, h_waddr, delta_q;
	logic [HCW-1:0] h_rdata, h_wdata, inc_n, bestn_q;
	logic           h_we;
	logic [15:0]    best_q;

	// scoring
	logic [HCW-1:0] here_q, here_n;
	logic           found_q, mism;
	logic [NCW-1:0] clean_q;
	logic [14:0]    dev_q;
	logic [DSW-1:0] dev_sum;
	logic [CW-1:0]  bch_q;
	logic [RW-1:0]  brow_q;
	logic [15:0]    bgot_q, bwant_q, want;

	// per-orientation summaries
	logic [NCW-1:0] s_clean_q  [2];
	logic [14:0]    s_dev_q    [2];
	logic [15:0]    s_stride_q [2];
	logic [CW-1:0]  s_bch_q    [2];
	logic [RW-1:0]  s_brow_q   [2];
	logic [15:0]    s_bgot_q   [2];
	logic [15:0]    s_bwant_q  [2];

	// equality pass
	logic           eq_q;
	logic [RW-1:0]  uneq_q;
	logic [15:0]    ref_q;

	logic out_valid_q, out_sel_q;

	assign accept = in_valid && cmd.load_en;
	assign fs_we  = accept;

	rpfc_ram #(.W(SampleW), .D(MAX_ROWS * MAX_CHANNELS)) u_frame (
		.clk   (clk),
		.we    (fs_we),
		.waddr (pos_q),
		.wdata (sample),
		.raddr (addr_q),
		.rdata (fs_rdata)
	);

	rpfc_ram #(.W(HCW), .D(HistDepth)) u_hist (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	assign rd_val  = cmd.swap ? bswap(fs_rdata) : fs_rdata;
	assign h_raddr = rd_val - prev_q;
	assign inc_n   = h_rdata + HCW'(1);
	assign want    = prev_q + best_q;
	assign mism    = !first_q && (rd_val != want);
	assign here_n  = here_q + HCW'(mism);
	assign dev_sum = DSW'(dev_q) + DSW'(here_n);

	always_comb begin
		h_we    = 1'b0;
		h_waddr = delta_q;
		h_wdata = '0;
		case (cmd.op)
			OP_HCLR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
			end
			OP_ST_INC: begin
				h_we    = 1'b1;
				h_wdata = inc_n;
			end
			OP_CL_CAP: begin
				h_we    = !first_q;
				h_waddr = h_raddr;
			end
			default: h_we = 1'b0;
		endcase
	end

	assign st.hclr_done   = (clr_q == HAW'(HistDepth - 1));
	assign st.walk_first  = first_q;
	assign st.row_end     = (NRW'(row_q) >= nrows - NRW'(1));
	assign st.ch_last     = (NCW'(ch_q) == nch - NCW'(1));
	assign st.eq_stop     = ((ch_q != '0) && (fs_rdata != ref_q)) ||
	                        (TW'(addr_q) == total - TW'(1));
	assign st.last_sample = (TW'(pos_q) == total - TW'(1));
	assign st.out_busy    = out_valid_q;
	assign st.one_row     = (nrows == NRW'(1));

	// load position and histogram clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			clr_q <= '0;
		end else begin
			if (restart) pos_q <= '0;
			else if (accept) pos_q <= st.last_sample ? '0 : pos_q + AW'(1);
			if (cmd.op == OP_HCLR) clr_q <= clr_q + HAW'(1);
		end
	end

	// walk and scoring
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ST_INIT, OP_WALK_INIT, OP_SC_INIT: begin
				addr_q  <= AW'(nch);
				row_q   <= RW'(1);
				ch_q    <= '0;
				first_q <= 1'b1;
				if (cmd.op == OP_ST_INIT) begin
					best_q  <= 16'd1;
					bestn_q <= '0;
				end
				if (cmd.op == OP_SC_INIT) begin
					here_q  <= '0;
					found_q <= 1'b0;
					clean_q <= '0;
					dev_q   <= '0;
					bch_q   <= '0;
					brow_q  <= '0;
					bgot_q  <= '0;
					bwant_q <= '0;
				end
			end
			OP_ST_CAP: begin
				prev_q  <= rd_val;
				delta_q <= h_raddr;
				if (first_q) begin
					first_q <= 1'b0;
					row_q   <= row_q + RW'(1);
					addr_q  <= addr_q + AW'(nch);
				end
			end
			OP_ST_INC: begin
				row_q  <= row_q + RW'(1);
				addr_q <= addr_q + AW'(nch);
				// ties keep the smallest delta
				if (inc_n > bestn_q || (inc_n == bestn_q && 16'(delta_q) < best_q)) begin
					bestn_q <= inc_n;
					best_q  <= 16'(delta_q);
				end
			end
			OP_CL_CAP: begin
				prev_q  <= rd_val;
				first_q <= 1'b0;
				row_q   <= row_q + RW'(1);
				addr_q  <= addr_q + AW'(nch);
			end
			OP_SC_CAP: begin
				prev_q  <= rd_val;
				first_q <= 1'b0;
				if (mism && !found_q) begin
					found_q <= 1'b1;
					bch_q   <= ch_q;
					brow_q  <= row_q;
					bgot_q  <= rd_val;
					bwant_q <= want;
				end
				if (st.row_end) begin
					// channel done
					if (here_n == '0) clean_q <= clean_q + NCW'(1);
					else dev_q <= (dev_sum > DSW'(DevMax)) ? DevMax : dev_sum[14:0];
					here_q  <= '0;
					ch_q    <= ch_q + CW'(1);
					row_q   <= RW'(1);
					first_q <= 1'b1;
					addr_q  <= AW'(nch) + AW'(ch_q) + AW'(1);
				end else begin
					here_q <= here_n;
					row_q  <= row_q + RW'(1);
					addr_q <= addr_q + AW'(nch);
				end
			end
			OP_SC_SAVE: begin
				s_clean_q[cmd.swap]  <= clean_q;
				s_dev_q[cmd.swap]    <= dev_q;
				s_stride_q[cmd.swap] <= best_q;
				s_bch_q[cmd.swap]    <= bch_q;
				s_brow_q[cmd.swap]   <= brow_q;
				s_bgot_q[cmd.swap]   <= bgot_q;
				s_bwant_q[cmd.swap]  <= bwant_q;
			end
			OP_EQ_INIT: begin
				addr_q <= AW'(nch);
				row_q  <= RW'(1);
				ch_q   <= '0;
			end
			OP_EQ_CAP: begin
				if (ch_q == '0) ref_q <= fs_rdata;
				addr_q <= addr_q + AW'(1);
				if (NCW'(ch_q) == nch - NCW'(1)) begin
					ch_q  <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					ch_q <= ch_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	// equality verdict and output beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_sel_q   <= 1'b0;
			eq_q        <= 1'b1;
			uneq_q      <= '0;
		end else begin
			if (cmd.op == OP_SC_SAVE && cmd.swap) begin
				eq_q   <= 1'b1;
				uneq_q <= '0;
			end else if (cmd.op == OP_EQ_CAP && ch_q != '0 && fs_rdata != ref_q) begin
				eq_q   <= 1'b0;
				uneq_q <= row_q;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
				out_sel_q   <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				if (out_sel_q) out_valid_q <= 1'b0;
				else out_sel_q <= 1'b1;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign orientation       = out_sel_q;
	assign last_result       = out_sel_q;
	assign verdict           = (s_clean_q[0] == nch) ? 2'd0 :
	                           (s_clean_q[1] == nch) ? 2'd1 : 2'd2;
	assign clean_channels    = 6'(s_clean_q[out_sel_q]);
	assign deviation_total   = s_dev_q[out_sel_q];
	assign ramp_stride       = s_stride_q[out_sel_q];
	assign bad_channel       = 5'(s_bch_q[out_sel_q]);
	assign bad_row           = 10'(s_brow_q[out_sel_q]);
	assign bad_got           = s_bgot_q[out_sel_q];
	assign bad_want          = s_bwant_q[out_sel_q];
	assign rows_equal        = eq_q;
	assign first_unequal_row = 10'(uneq_q);

	a_out_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> !out_valid_q)
		else $error("result started over a pending one");

	a_load_only_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fs_we |-> (cmd.op == OP_NONE))
		else $error("frame write during a pass");

	a_second_beat_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ready && !out_sel_q |=> out_valid_q && out_sel_q)
		else $error("second result beat missing");
endmodule

[sv/ramp_pattern_frame_checker.sv]
// ----------------------------------------------------------------------------
// ramp_pattern_frame_checker
// Collects a frame of samples and checks it for a clean ramp, native and
// byte-swapped, plus an all-channels-equal check.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | in_valid / in_ready     | sample
//  result   | out_valid / out_ready   | orientation .. last_result
//  config   | cfg_wr_en               | cfg_index, cfg_wdata
//
// samples load one a beat while in_ready is high; after the last sample of a
// frame the check runs sequentially on one frame store read port: per
// orientation a stride pass, a pass to clear the histogram and a scoring pass,
// then an equality pass that stops at the first mismatch, two result beats.
// after reset a clearing pass runs over all 65536 histogram entries; no
// sample is taken until it ends. samples of the next frame are taken while
// results wait, but not its last sample.
// ----------------------------------------------------------------------------
module ramp_pattern_frame_checker #(
	parameter int MAX_ROWS     = rpfc_pkg::MaxRowsDef,
	parameter int MAX_CHANNELS = rpfc_pkg::MaxChannelsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rpfc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rpfc_pkg::CfgW-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [15:0]                   sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          orientation,
	output logic [1:0]                    verdict,
	output logic [5:0]                    clean_channels,
	output logic [14:0]                   deviation_total,
	output logic [15:0]                   ramp_stride,
	output logic [4:0]                    bad_channel,
	output logic [9:0]                    bad_row,
	output logic [15:0]                   bad_got,
	output logic [15:0]                   bad_want,
	output logic                          rows_equal,
	output logic [9:0]                    first_unequal_row,
	output logic                          last_result
);
	import rpfc_pkg::*;

	localparam int NRW = $clog2(MAX_ROWS + 1);
	localparam int NCW = $clog2(MAX_CHANNELS + 1);
	localparam int TW  = $clog2(MAX_ROWS * MAX_CHANNELS + 1);

	logic [RowsRegW-1:0] rows_q;
	logic [ChRegW-1:0]   chans_q;
	logic [NRW-1:0]      nrows;
	logic [NCW-1:0]      nch;
	logic [TW-1:0]       total;
	logic                restart;
	dp_cmd_t             cmd;
	dp_stat_t            st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= RowsReset;
			chans_q <= ChReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROWS:     rows_q  <= cfg_wdata[RowsRegW-1:0];
				REG_CHANNELS: chans_q <= cfg_wdata[ChRegW-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_wr_en && (cfg_index == REG_ROWS || cfg_index == REG_CHANNELS);

	// out-of-range settings clamp to the supported span
	always_comb begin
		if (rows_q == '0) nrows = NRW'(1);
		else if (32'(rows_q) > MAX_ROWS) nrows = NRW'(MAX_ROWS);
		else nrows = NRW'(rows_q);
		if (chans_q == '0) nch = NCW'(1);
		else if (32'(chans_q) > MAX_CHANNELS) nch = NCW'(MAX_CHANNELS);
		else nch = NCW'(chans_q);
	end

	assign total = TW'(nrows) * TW'(nch);

	rpfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rpfc_dp #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.nrows             (nrows),
		.nch               (nch),
		.total             (total),
		.restart           (restart),
		.in_valid          (in_valid),
		.sample            (sample),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.orientation       (orientation),
		.verdict           (verdict),
		.clean_channels    (clean_channels),
		.deviation_total   (deviation_total),
		.ramp_stride       (ramp_stride),
		.bad_channel       (bad_channel),
		.bad_row           (bad_row),
		.bad_got           (bad_got),
		.bad_want          (bad_want),
		.rows_equal        (rows_equal),
		.first_unequal_row (first_unequal_row),
		.last_result       (last_result)
	);
endmodule
